// File: sv/lacs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacs_pkg
// types, register codes and arithmetic helpers for the chroma subsampler
// ----------------------------------------------------------------------------
package lacs_pkg;

    // one input group: four luma and two times four chroma samples
    typedef struct packed {
        logic [7:0] luma_s0;
        logic [7:0] luma_s1;
        logic [7:0] luma_s2;
        logic [7:0] luma_s3;
        logic [7:0] u_s0;
        logic [7:0] u_s1;
        logic [7:0] u_s2;
        logic [7:0] u_s3;
        logic [7:0] v_s0;
        logic [7:0] v_s1;
        logic [7:0] v_s2;
        logic [7:0] v_s3;
    } in_t;

    // one subsampled chroma pair
    typedef struct packed {
        logic [7:0] u_out;
        logic [7:0] v_out;
    } out_t;

    // subsampling modes
    localparam logic [1:0] MODE_444 = 2'd0;
    localparam logic [1:0] MODE_422 = 2'd1;
    localparam logic [1:0] MODE_420 = 2'd2;
    localparam logic [1:0] MODE_411 = 2'd3;

    // configuration register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_ADAPT = 1'b1;

    localparam int CFG_DATA_W = 2;

    // reset values
    localparam logic [1:0] MODE_RESET  = MODE_420;
    localparam logic       ADAPT_RESET = 1'b1;

    // luma activity thresholds
    localparam logic [9:0] THRESH_QUAD = 10'd96;
    localparam logic [8:0] THRESH_PAIR = 9'd48;

    function automatic logic [7:0] mean2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [7:0] mean4(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d);
        logic [9:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d} + 10'd2;
        return s[9:2];
    endfunction

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    // push the mean away from 128 by (256 - lav) * (cav - 128) / 256,
    // quotient truncated toward zero, then clamp to [lo, hi]
    function automatic logic [7:0] push_clamp(input logic [7:0] cav, input logic [7:0] lav,
                                              input logic [7:0] lo, input logic [7:0] hi);
        logic        [8:0]  w;
        logic signed [18:0] wx;
        logic signed [18:0] dx;
        logic signed [18:0] p;
        logic signed [18:0] q;
        logic signed [10:0] v;
        w  = 9'd256 - {1'b0, lav};
        wx = $signed({10'b0, w});
        dx = $signed({11'b0, cav}) - 19'sd128;
        p  = wx * dx;
        q  = p[18] ? ((p + 19'sd255) >>> 8) : (p >>> 8);
        v  = $signed({3'b0, cav}) + q[10:0];
        if (v < $signed({3'b0, lo})) begin
            return lo;
        end
        if (v > $signed({3'b0, hi})) begin
            return hi;
        end
        return v[7:0];
    endfunction

endpackage

// File: sv/lacs_chroma_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacs_chroma_calc
// combinational means, luma activity, push and clamp for one group
// ----------------------------------------------------------------------------
module lacs_chroma_calc
    import lacs_pkg::*;
(
    input  in_t        grp,
    input  logic [1:0] mode,
    input  logic       adapt,
    output out_t       res
);

    logic [7:0] lav01, lav23, lav4;
    logic [8:0] act01, act23;
    logic [9:0] act4;
    logic [7:0] u_m2, v_m2, u_m4, v_m4;
    logic [7:0] u_lo2, u_hi2, v_lo2, v_hi2, u_lo4, u_hi4, v_lo4, v_hi4;
    logic [7:0] u_cav, v_cav, u_lav, v_lav, u_lo, u_hi, v_lo, v_hi;
    logic       push;

    // luma means and activity
    assign lav01 = mean2(grp.luma_s0, grp.luma_s1);
    assign lav23 = mean2(grp.luma_s2, grp.luma_s3);
    assign lav4  = mean4(grp.luma_s0, grp.luma_s1, grp.luma_s2, grp.luma_s3);

    assign act01 = {1'b0, absdiff(grp.luma_s0, lav01)} + {1'b0, absdiff(grp.luma_s1, lav01)};
    assign act23 = {1'b0, absdiff(grp.luma_s2, lav23)} + {1'b0, absdiff(grp.luma_s3, lav23)};
    assign act4  = {2'b0, absdiff(grp.luma_s0, lav4)} + {2'b0, absdiff(grp.luma_s1, lav4)}
                 + {2'b0, absdiff(grp.luma_s2, lav4)} + {2'b0, absdiff(grp.luma_s3, lav4)};

    // chroma means and ranges
    assign u_m2 = mean2(grp.u_s0, grp.u_s1);
    assign v_m2 = mean2(grp.v_s0, grp.v_s1);
    assign u_m4 = mean4(grp.u_s0, grp.u_s1, grp.u_s2, grp.u_s3);
    assign v_m4 = mean4(grp.v_s0, grp.v_s1, grp.v_s2, grp.v_s3);

    assign u_lo2 = min2(grp.u_s0, grp.u_s1);
    assign u_hi2 = max2(grp.u_s0, grp.u_s1);
    assign v_lo2 = min2(grp.v_s0, grp.v_s1);
    assign v_hi2 = max2(grp.v_s0, grp.v_s1);
    assign u_lo4 = min2(u_lo2, min2(grp.u_s2, grp.u_s3));
    assign u_hi4 = max2(u_hi2, max2(grp.u_s2, grp.u_s3));
    assign v_lo4 = min2(v_lo2, min2(grp.v_s2, grp.v_s3));
    assign v_hi4 = max2(v_hi2, max2(grp.v_s2, grp.v_s3));

    always_comb
    begin
        u_cav = u_m4;
        v_cav = v_m4;
        u_lav = lav4;
        v_lav = lav4;
        u_lo  = u_lo4;
        u_hi  = u_hi4;
        v_lo  = v_lo4;
        v_hi  = v_hi4;
        push  = 1'b0;
        unique case (mode)
            MODE_422:
            begin
                u_cav = u_m2;
                v_cav = v_m2;
                u_lav = lav01;
                v_lav = lav01;
                u_lo  = u_lo2;
                u_hi  = u_hi2;
                v_lo  = v_lo2;
                v_hi  = v_hi2;
                push  = adapt && (act01 >= THRESH_PAIR);
            end
            MODE_420:
            begin
                push = adapt && (act4 >= THRESH_QUAD);
            end
            MODE_411:
            begin
                // u follows the left pair's luma, v the right pair's
                u_lav = lav01;
                v_lav = lav23;
                push  = adapt && (act01 >= THRESH_PAIR) && (act23 >= THRESH_PAIR);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (mode == MODE_444) begin
            res.u_out = grp.u_s0;
            res.v_out = grp.v_s0;
        end else if (push) begin
            res.u_out = push_clamp(u_cav, u_lav, u_lo, u_hi);
            res.v_out = push_clamp(v_cav, v_lav, v_lo, v_hi);
        end else begin
            res.u_out = u_cav;
            res.v_out = v_cav;
        end
    end

endmodule

// File: sv/luma_adaptive_chroma_subsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_adaptive_chroma_subsampler
// turns one group of luma and chroma samples into one subsampled chroma pair
// ----------------------------------------------------------------------------
//
//  channel  | signals                        | payload
//  ---------+--------------------------------+---------------------------
//  input    | in_valid / in_ready / in_data  | in_t  (4 luma, 4 u, 4 v)
//  output   | out_valid / out_ready / out_data | out_t (u_out, v_out)
//  config   | cfg_wr_en / cfg_index / cfg_data | mode, adaptive enable
//
//  one group per clock sustained while out_ready stays high; an accepted group
//  is held in the input register, then its result in the output register
//  the input register feeds the calc logic, the result register holds the
//  answer; both advance together when the result is taken or empty
//  a stalled output fills the input register, then in_ready drops
//  rst_n is asynchronous, active low; it empties both stages and sets mode
//  4:2:0 with adaptive push on
//
module luma_adaptive_chroma_subsampler
    import lacs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel group input
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    // chroma pair output
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data
);

    logic [1:0] mode_reg;
    logic       adapt_reg;

    logic       s1_valid_reg;
    in_t        s1_data_reg;
    logic       s2_valid_reg;
    out_t       s2_data_reg;

    logic       s1_advance;
    out_t       calc_res;

    // configuration registers, only the low bits of each write kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_RESET;
            adapt_reg <= ADAPT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_ADAPT: adapt_reg <= cfg_data[0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // the input stage moves on when the result register is free or being read
    assign s1_advance = !s2_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_data_reg <= in_data;
        end
    end

    lacs_chroma_calc u_calc (
        .grp   (s1_data_reg),
        .mode  (mode_reg),
        .adapt (adapt_reg),
        .res   (calc_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg) begin
            s2_data_reg <= calc_res;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// File: sv/lacs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacs_checker
// port level checks on transfers through the chroma subsampler
// ----------------------------------------------------------------------------
module lacs_checker
    import lacs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // a stalled input group holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input group dropped or changed while stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    // with the result register empty the block always takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a fresh result follows a matching input transfer through the input register
    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching input transfer");

endmodule

bind luma_adaptive_chroma_subsampler lacs_checker u_lacs_checker (.*);
